FILE: sv/gcb_pkg.sv
// ----------------------------------------------------------------------------
// gcb_pkg
// Shared types and constants for the greedy coin change breakdown block.
// ----------------------------------------------------------------------------
package gcb_pkg;

    localparam int MAX_DENOMS  = 7;
    localparam int AMOUNT_BITS = 16;
    localparam int DENOM_BITS  = 16;
    localparam int CNT_BITS    = 7;
    localparam int NCNT_BITS   = 3;
    localparam int IDX_BITS    = $clog2(MAX_DENOMS);
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CNT_BITS-1:0] COUNT_CAP = CNT_BITS'(99);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DENOM_COUNT = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_DENOM_FIRST = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_DENOM_LAST  = CFG_IDX_BITS'(MAX_DENOMS);

    localparam logic [NCNT_BITS-1:0] DENOM_COUNT_RESET = NCNT_BITS'(7);

    localparam logic [DENOM_BITS-1:0] DENOM_RESET [MAX_DENOMS] = '{
        16'd100, 16'd50, 16'd20, 16'd10, 16'd5, 16'd2, 16'd1
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COUNT,
        ST_EMIT
    } t_state;

endpackage

FILE: sv/gcb_in_if.sv
// ----------------------------------------------------------------------------
// gcb_in_if
// Input channel: one change amount per transfer.
// ----------------------------------------------------------------------------
interface gcb_in_if;
    logic                             valid;
    logic                             ready;
    logic [gcb_pkg::AMOUNT_BITS-1:0]  amount_cents;

    modport source (output valid, output amount_cents, input ready);
    modport sink   (input valid, input amount_cents, output ready);
endinterface

FILE: sv/gcb_out_if.sv
// ----------------------------------------------------------------------------
// gcb_out_if
// Result channel: one denomination and its coin count per transfer.
// ----------------------------------------------------------------------------
interface gcb_out_if;
    logic                            valid;
    logic                            ready;
    logic [gcb_pkg::DENOM_BITS-1:0]  denom_value;
    logic [gcb_pkg::CNT_BITS-1:0]    coin_count;
    logic                            last_result;

    modport source (output valid, output denom_value, output coin_count,
                    output last_result, input ready);
    modport sink   (input valid, input denom_value, input coin_count,
                    input last_result, output ready);
endinterface

FILE: sv/gcb_cfg_if.sv
// ----------------------------------------------------------------------------
// gcb_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gcb_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [gcb_pkg::CFG_IDX_BITS-1:0]   index;
    logic [gcb_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/greedy_change_breakdown_top.sv
// ----------------------------------------------------------------------------
// greedy_change_breakdown_top
// Sequence: after an amount is accepted, for each denomination in use the block
//   scans the active registers for the largest unused one, subtracts it until
//   the remainder is smaller or the coin count hits the cap of 99, then emits it.
// Throughput: one amount at a time; input ready only while idle. The single
//   subtractor/comparator loop sets the pace. Results sit in an output reg.
// Reset: synchronous active low; registers return to 7 denominations of
//   100, 50, 20, 10, 5, 2, 1 cents and the sequencer goes idle.
// ----------------------------------------------------------------------------
module greedy_change_breakdown_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gcb_in_if.sink      i_in,
    gcb_out_if.source   o_out,
    gcb_cfg_if.sink     i_cfg
);

    localparam int DB = gcb_pkg::DENOM_BITS;
    localparam int CB = gcb_pkg::CNT_BITS;
    localparam int IB = gcb_pkg::IDX_BITS;
    localparam int NB = gcb_pkg::NCNT_BITS;
    localparam int ND = gcb_pkg::MAX_DENOMS;

    // configuration registers
    logic [NB-1:0]  r_denom_count;
    logic [DB-1:0]  r_denom [ND];

    // sequencer and datapath
    gcb_pkg::t_state r_state, n_state;
    logic [gcb_pkg::AMOUNT_BITS-1:0] r_rem;
    logic [CB-1:0]  r_cnt;
    logic [DB-1:0]  r_d;
    logic [NB-1:0]  r_n;
    logic [NB-1:0]  r_pos;
    logic [IB-1:0]  r_idx;
    logic [DB-1:0]  r_best;
    logic [IB-1:0]  r_best_idx;
    logic           r_have;
    logic [ND-1:0]  r_used;

    // output register
    logic           r_out_valid;
    logic [DB-1:0]  r_out_denom;
    logic [CB-1:0]  r_out_count;
    logic           r_out_last;

    logic           in_xfer;
    logic           out_free;
    logic           ld_out;
    logic           scan_last;
    logic           scan_take;
    logic           count_go;
    logic           pos_last;
    logic [DB-1:0]  cand_best;
    logic [IB-1:0]  cand_idx;
    logic [NB-1:0]  active_n;
    logic [gcb_pkg::CFG_IDX_BITS-1:0] cfg_off;

    assign i_cfg.ready = 1'b1;
    assign cfg_off     = i_cfg.index - gcb_pkg::CFG_DENOM_FIRST;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_denom_count <= gcb_pkg::DENOM_COUNT_RESET;
            r_denom       <= gcb_pkg::DENOM_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == gcb_pkg::CFG_DENOM_COUNT) begin
                r_denom_count <= i_cfg.data[NB-1:0];
            end else if (i_cfg.index >= gcb_pkg::CFG_DENOM_FIRST &&
                         i_cfg.index <= gcb_pkg::CFG_DENOM_LAST) begin
                r_denom[cfg_off[IB-1:0]] <= i_cfg.data[DB-1:0];
            end
        end
    end

    // a count of zero still means one denomination
    assign active_n = (r_denom_count == '0) ? NB'(1) : r_denom_count;

    // shared compare: strict greater keeps ties in register order
    assign scan_take = !r_used[r_idx] && (!r_have || r_denom[r_idx] > r_best);
    assign cand_best = scan_take ? r_denom[r_idx] : r_best;
    assign cand_idx  = scan_take ? r_idx : r_best_idx;
    assign scan_last = (NB'(r_idx) == r_n - NB'(1));
    assign count_go  = (r_cnt < gcb_pkg::COUNT_CAP) && (r_rem >= r_d);
    assign pos_last  = (r_pos == r_n - NB'(1));
    assign out_free  = !r_out_valid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gcb_pkg::ST_IDLE:  if (i_in.valid) n_state = gcb_pkg::ST_SCAN;
            gcb_pkg::ST_SCAN:  if (scan_last) n_state = gcb_pkg::ST_COUNT;
            gcb_pkg::ST_COUNT: if (!count_go) n_state = gcb_pkg::ST_EMIT;
            gcb_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = pos_last ? gcb_pkg::ST_IDLE : gcb_pkg::ST_SCAN;
                end
            end
            default: n_state = gcb_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        i_in.ready = 1'b0;
        ld_out     = 1'b0;
        unique case (r_state)
            gcb_pkg::ST_IDLE:  i_in.ready = 1'b1;
            gcb_pkg::ST_EMIT:  ld_out = out_free;
            default: ;
        endcase
    end

    assign in_xfer = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gcb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem      <= '0;
            r_cnt      <= '0;
            r_pos      <= '0;
            r_idx      <= '0;
            r_have     <= 1'b0;
            r_used     <= '0;
            r_n        <= NB'(1);
            r_d        <= '0;
            r_best     <= '0;
            r_best_idx <= '0;
        end else begin
            unique case (r_state)
                gcb_pkg::ST_IDLE: begin
                    if (in_xfer) begin
                        r_rem  <= i_in.amount_cents;
                        r_pos  <= '0;
                        r_idx  <= '0;
                        r_have <= 1'b0;
                        r_used <= '0;
                        r_n    <= active_n;
                    end
                end
                gcb_pkg::ST_SCAN: begin
                    r_best     <= cand_best;
                    r_best_idx <= cand_idx;
                    r_have     <= r_have || scan_take;
                    r_idx      <= r_idx + IB'(1);
                    if (scan_last) begin
                        r_d              <= cand_best;
                        r_used[cand_idx] <= 1'b1;
                        r_cnt            <= '0;
                    end
                end
                gcb_pkg::ST_COUNT: begin
                    if (count_go) begin
                        r_rem <= r_rem - r_d;
                        r_cnt <= r_cnt + CB'(1);
                    end
                end
                gcb_pkg::ST_EMIT: begin
                    if (out_free) begin
                        r_pos  <= r_pos + NB'(1);
                        r_idx  <= '0;
                        r_have <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_denom <= r_d;
            r_out_count <= r_cnt;
            r_out_last  <= pos_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.denom_value = r_out_denom;
    assign o_out.coin_count  = r_out_count;
    assign o_out.last_result = r_out_last;

    // checks
    a_cnt_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= gcb_pkg::COUNT_CAP)
        else $error("coin count above cap");

    a_used_tracks_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gcb_pkg::ST_SCAN) |-> ($countones(r_used) == int'(r_pos)))
        else $error("used mask out of step with result position");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == gcb_pkg::ST_SCAN))
        else $error("accepted amount did not start a scan");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_out && pos_last) |=> (r_state == gcb_pkg::ST_IDLE && o_out.valid
                                  && o_out.last_result))
        else $error("last result did not return the sequencer to idle");

endmodule

FILE: bench/greedy_change_breakdown_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_change_breakdown_top_tb
// Drives change amounts into the coin breakdown block under a series of
// denomination settings and checks every denomination/count result against
// an in-bench greedy split. Directed corner cases come first, then random
// settings and amounts with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module greedy_change_breakdown_top_tb;

    localparam int AW = gcb_pkg::AMOUNT_BITS;
    localparam int DW = gcb_pkg::DENOM_BITS;
    localparam int CW = gcb_pkg::CNT_BITS;
    localparam int NW = gcb_pkg::NCNT_BITS;
    localparam int IW = gcb_pkg::IDX_BITS;
    localparam int XW = gcb_pkg::CFG_IDX_BITS;
    localparam int VW = gcb_pkg::CFG_DATA_BITS;
    localparam int HW = VW - NW;
    localparam int ND = gcb_pkg::MAX_DENOMS;

    localparam logic [XW-1:0] CFG_IDX_TOP = '1;
    localparam int RANDOM_PHASES    = 10;
    localparam int AMOUNTS_PER_PHASE = 35;

    typedef struct packed {
        logic [DW-1:0] denom;
        logic [CW-1:0] coins;
        logic          last;
    } t_coin_slot;

    logic i_clk;
    logic i_rst_n;

    gcb_in_if  in_if  ();
    gcb_out_if out_if ();
    gcb_cfg_if cfg_if ();

    greedy_change_breakdown_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    logic [AW-1:0]  amounts_to_send [$];
    t_coin_slot     owed_coins [$];
    int unsigned    mismatches;
    int unsigned    send_gap_pct;
    int unsigned    take_stall_pct;

    // mirror of the register file as the block should see it
    logic [NW-1:0]  cur_count;
    logic [DW-1:0]  cur_denoms [ND];

    always #5 i_clk = ~i_clk;

    // greedy split of one amount over the sorted denominations in use
    function automatic void split_amount(input logic [AW-1:0] amount);
        logic [DW-1:0] order [ND];
        logic [DW-1:0] v;
        int unsigned   n;
        int unsigned   left;
        int unsigned   cnt;
        int            j;
        t_coin_slot    slot;
        n = (cur_count == '0) ? 1 : int'(cur_count);
        if (n > ND) n = ND;
        // stable descending insertion sort, ties stay in register order
        for (int i = 0; i < n; i++) begin
            v = cur_denoms[IW'(i)];
            j = i;
            while (j > 0 && order[IW'(j-1)] < v) begin
                order[IW'(j)] = order[IW'(j-1)];
                j--;
            end
            order[IW'(j)] = v;
        end
        left = 32'(amount);
        for (int k = 0; k < n; k++) begin
            if (order[IW'(k)] == '0) begin
                cnt = 32'(gcb_pkg::COUNT_CAP);
            end else begin
                cnt = left / order[IW'(k)];
                if (cnt > gcb_pkg::COUNT_CAP) cnt = 32'(gcb_pkg::COUNT_CAP);
                left = left - cnt * order[IW'(k)];
            end
            slot.denom = order[IW'(k)];
            slot.coins = CW'(cnt);
            slot.last  = (k == n - 1);
            owed_coins.push_back(slot);
        end
    endfunction

    task automatic write_reg(input logic [XW-1:0] idx,
                             input logic [VW-1:0] val);
        logic [IW-1:0] off;
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == gcb_pkg::CFG_DENOM_COUNT) begin
            cur_count = val[NW-1:0];
        end else if (idx >= gcb_pkg::CFG_DENOM_FIRST && idx <= gcb_pkg::CFG_DENOM_LAST) begin
            off = IW'(idx - gcb_pkg::CFG_DENOM_FIRST);
            cur_denoms[off] = val;
        end
    endtask

    // hold off until every queued amount is taken and all its results are back
    task automatic drain();
        while (amounts_to_send.size() != 0 || in_if.valid || owed_coins.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : amount_driver
        bit holding;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            holding = in_if.valid;
            if (in_if.valid && in_if.ready) begin
                split_amount(in_if.amount_cents);
                holding = 1'b0;
            end
            if (!holding) begin
                if (amounts_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    in_if.amount_cents <= amounts_to_send.pop_front();
                    in_if.valid        <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_coin_slot want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (owed_coins.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected no result, actual denom %0d coins %0d last %0d",
                             $time, out_if.denom_value, out_if.coin_count,
                             out_if.last_result);
                end else begin
                    want = owed_coins.pop_front();
                    if (out_if.denom_value !== want.denom) begin
                        mismatches++;
                        $display("%0t: denom_value expected %0d actual %0d",
                                 $time, want.denom, out_if.denom_value);
                    end
                    if (out_if.coin_count !== want.coins) begin
                        mismatches++;
                        $display("%0t: coin_count expected %0d actual %0d (denom %0d)",
                                 $time, want.coins, out_if.coin_count, want.denom);
                    end
                    if (out_if.last_result !== want.last) begin
                        mismatches++;
                        $display("%0t: last_result expected %0d actual %0d (denom %0d)",
                                 $time, want.last, out_if.last_result, want.denom);
                    end
                end
            end
            out_if.ready <= ($urandom_range(99) >= take_stall_pct);
        end
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int unsigned    roll;
        logic [AW-1:0]  amt;
        logic [DW-1:0]  dv;

        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.amount_cents = '0;
        out_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        mismatches         = 0;
        send_gap_pct       = 11;
        take_stall_pct     = 57;
        cur_count          = gcb_pkg::DENOM_COUNT_RESET;
        for (int i = 0; i < ND; i++) cur_denoms[IW'(i)] = gcb_pkg::DENOM_RESET[IW'(i)];

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset denominations: empty amount, one of each coin, cap on the top coin
        amounts_to_send.push_back(16'd0);
        amounts_to_send.push_back(16'd1);
        amounts_to_send.push_back(16'd188);
        amounts_to_send.push_back(16'd9999);
        amounts_to_send.push_back(16'd10000);
        amounts_to_send.push_back(16'hFFFF);
        drain();

        // count of zero acts as one; a zero coin always counts to the cap;
        // writes past the register list must change nothing
        write_reg(gcb_pkg::CFG_DENOM_COUNT, 16'hFFF8);
        write_reg(gcb_pkg::CFG_DENOM_FIRST, 16'h0000);
        write_reg(XW'(gcb_pkg::CFG_DENOM_LAST + 1), 16'hFFFF);
        write_reg(CFG_IDX_TOP, 16'h0001);
        amounts_to_send.push_back(16'd0);
        amounts_to_send.push_back(16'hFFFF);
        drain();

        // full set with ties, a zero and the largest value
        write_reg(gcb_pkg::CFG_DENOM_COUNT, 16'h0007);
        write_reg(XW'(gcb_pkg::CFG_DENOM_FIRST + 0), 16'hFFFF);
        write_reg(XW'(gcb_pkg::CFG_DENOM_FIRST + 1), 16'h0000);
        write_reg(XW'(gcb_pkg::CFG_DENOM_FIRST + 2), 16'd7);
        write_reg(XW'(gcb_pkg::CFG_DENOM_FIRST + 3), 16'd7);
        write_reg(XW'(gcb_pkg::CFG_DENOM_FIRST + 4), 16'd1);
        write_reg(XW'(gcb_pkg::CFG_DENOM_FIRST + 5), 16'hFFFF);
        write_reg(XW'(gcb_pkg::CFG_DENOM_FIRST + 6), 16'd3);
        amounts_to_send.push_back(16'hFFFF);
        amounts_to_send.push_back(16'd17);
        amounts_to_send.push_back(16'd1000);
        amounts_to_send.push_back(16'd0);
        drain();

        // single one-cent coin: cap reached, the rest is dropped
        write_reg(gcb_pkg::CFG_DENOM_COUNT, 16'hFFF9);
        write_reg(gcb_pkg::CFG_DENOM_FIRST, 16'd1);
        amounts_to_send.push_back(16'hFFFF);
        amounts_to_send.push_back(16'd98);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 4) begin
                send_gap_pct   = 11;
                take_stall_pct = 57;
            end else if (p < 7) begin
                send_gap_pct   = 57;
                take_stall_pct = 11;
            end else begin
                send_gap_pct   = 0;
                take_stall_pct = 0;
            end

            write_reg(gcb_pkg::CFG_DENOM_COUNT,
                      {HW'($urandom), NW'($urandom_range(0, 7))});
            for (int r = 0; r < ND; r++) begin
                roll = $urandom_range(99);
                if (roll < 5)       dv = '0;
                else if (roll < 10) dv = '1;
                else if (roll < 50) dv = DW'($urandom_range(1, 25));
                else if (roll < 80) dv = DW'($urandom_range(26, 500));
                else                dv = DW'($urandom);
                write_reg(XW'(gcb_pkg::CFG_DENOM_FIRST + r), dv);
            end
            if ($urandom_range(1) == 1)
                write_reg(XW'($urandom_range(int'(gcb_pkg::CFG_DENOM_LAST) + 1,
                                             int'(CFG_IDX_TOP))),
                          VW'($urandom));

            for (int a = 0; a < AMOUNTS_PER_PHASE; a++) begin
                roll = $urandom_range(99);
                if (roll < 55)      amt = AW'($urandom_range(0, 3000));
                else if (roll < 85) amt = AW'($urandom);
                else amt = AW'(cur_denoms[IW'($urandom_range(0, ND - 1))]
                               + $urandom_range(0, 2) - 1);
                amounts_to_send.push_back(amt);
                // mid-phase hold-off until the block has handed everything back
                if (p == 2 && a == AMOUNTS_PER_PHASE / 2) drain();
            end
            drain();
        end

        // catch any stray result after the last expected one
        repeat (800) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
